@@ hw/rtl/conv3x3_tile_filter_macros.svh @@
// Assertion helpers
`ifndef CONV3X3_TILE_FILTER_MACROS_SVH
`define CONV3X3_TILE_FILTER_MACROS_SVH

`define C3_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define C3_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ hw/rtl/c3tf_pkg.sv @@
package c3tf_pkg;
	localparam int TILE_ROWS_DEF = 64;
	localparam int MAX_TILE_COLUMNS_DEF = 1024;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2 = 2'd3;
	localparam logic [7:0] PIX_MAX = 8'd255;

	typedef struct packed {
		logic [7:0] win_00;
		logic [7:0] win_01;
		logic [7:0] win_02;
		logic [7:0] win_10;
		logic [7:0] win_11;
		logic [7:0] win_12;
		logic [7:0] win_20;
		logic [7:0] win_21;
		logic [7:0] win_22;
		logic       column_done;
		logic       tile_done;
	} win_item_t;
endpackage

@@ hw/rtl/c3tf_front.sv @@
module c3tf_front import c3tf_pkg::*; #(
	parameter int TILE_ROWS = TILE_ROWS_DEF,
	parameter int MAX_TILE_COLUMNS = MAX_TILE_COLUMNS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        pixel,
	output logic              in_stall,
	input  logic [10:0]       tile_columns,
	output logic              item_valid,
	output win_item_t         item,
	input  logic              item_stall
);
	localparam int COL_LEN = TILE_ROWS + 2;
	localparam int AW = $clog2(COL_LEN);
	localparam int CW = 17;

	// Each entry k holds {older,middle} pair
	logic [15:0] col_mem [COL_LEN];
	logic [10:0] row_q;
	logic [CW-1:0] col_q;
	logic [15:0] newest_two_rows_q;
	logic wr_pend_q;
	logic acc, col_end, tile_end, emits;
	logic [CW-1:0] last_col;
	logic [16:0] cols;

	// Pipeline stage 1: window read
	logic        v_s1;
	logic [7:0]  p_s1, prev1_s1, prev2_s1;
	logic [10:0] row_s1;
	logic        emit_s1, cend_s1, tend_s1;
	logic [15:0] pa_s1, pb_s1, pc_s1;

	assign in_stall = v_s1 && item_stall;
	assign acc = in_valid && !in_stall;
	assign cols = (tile_columns > 11'(MAX_TILE_COLUMNS > 2047 ? 2047 : MAX_TILE_COLUMNS))
		? 17'(MAX_TILE_COLUMNS) : 17'(tile_columns);
	assign last_col = CW'(cols) + CW'(1);
	assign col_end = row_q >= 11'(COL_LEN - 1);
	assign tile_end = col_end && (col_q >= last_col);
	assign emits = col_q >= CW'(2) && row_q >= 11'd2 && row_q < 11'(COL_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			newest_two_rows_q <= '0;
			wr_pend_q <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			if (!in_stall)
				v_s1 <= acc;
			if (acc) begin
				wr_pend_q <= 1'b1;
				newest_two_rows_q <= {newest_two_rows_q[7:0], pixel};
				if (col_end) begin
					row_q <= '0;
					col_q <= tile_end ? '0 : col_q + CW'(1);
				end else begin
					row_q <= row_q + 11'd1;
				end
			end
		end
	end

	// Entry r is read at row r; rows r-2 and r-1 ride along in the window shift.
	// The entry moves on at the next transaction, from the stage 1 copy.
	always_ff @(posedge clk) begin
		if (acc) begin
			p_s1 <= pixel;
			prev1_s1 <= newest_two_rows_q[7:0];
			prev2_s1 <= newest_two_rows_q[15:8];
			row_s1 <= row_q;
			emit_s1 <= emits;
			cend_s1 <= col_end;
			tend_s1 <= tile_end;
			pa_s1 <= pb_s1;
			pb_s1 <= pc_s1;
			pc_s1 <= col_mem[AW'(row_q)];
			if (wr_pend_q)
				col_mem[AW'(row_s1)] <= {pc_s1[7:0], p_s1};
		end
	end

	assign item_valid = v_s1 && emit_s1;
	always_comb begin
		item.win_00 = pa_s1[15:8];
		item.win_01 = pa_s1[7:0];
		item.win_02 = prev2_s1;
		item.win_10 = pb_s1[15:8];
		item.win_11 = pb_s1[7:0];
		item.win_12 = prev1_s1;
		item.win_20 = pc_s1[15:8];
		item.win_21 = pc_s1[7:0];
		item.win_22 = p_s1;
		item.column_done = cend_s1;
		item.tile_done = tend_s1;
	end

	`include "conv3x3_tile_filter_macros.svh"
	`C3_ASSERT(a_row_range, (row_q <= 11'(COL_LEN - 1)), "row out of range")
	`C3_ASSERT(a_tile_end_col, (acc && tile_end) |=> (col_q == '0), "tile end must wrap column")
	`C3_ASSERT(a_hold, (v_s1 && item_stall) |=> ($stable(p_s1) && v_s1), "stalled item changed")
endmodule

@@ hw/rtl/c3tf_back.sv @@
module c3tf_back import c3tf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  win_item_t   item,
	output logic        item_stall,
	input  logic [47:0] coef_row0,
	input  logic [47:0] coef_row1,
	input  logic [47:0] coef_row2,
	output logic        out_valid,
	input  logic        stall,
	output logic [7:0]  out_pixel,
	output logic        column_done,
	output logic        tile_done
);
	typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DIV, ST_OUT} state_t;
	state_t state_q;
	logic [3:0] step_q;
	logic signed [35:0] sum_q;
	logic signed [19:0] div_q;
	logic [35:0] rem_q, quo_q, num_q;
	logic [19:0] den_q;
	logic neg_q;
	logic [5:0] bit_q;
	win_item_t it_q;
	logic signed [15:0] k;
	logic [7:0] px;
	logic [47:0] rowbits;
	logic [36:0] trial;

	always_comb begin
		case (step_q)
			4'd0, 4'd1, 4'd2: rowbits = coef_row0;
			4'd3, 4'd4, 4'd5: rowbits = coef_row1;
			default:          rowbits = coef_row2;
		endcase
		case (step_q)
			4'd0, 4'd3, 4'd6: k = rowbits[15:0];
			4'd1, 4'd4, 4'd7: k = rowbits[31:16];
			default:          k = rowbits[47:32];
		endcase
		case (step_q)
			4'd0: px = it_q.win_00;
			4'd1: px = it_q.win_01;
			4'd2: px = it_q.win_02;
			4'd3: px = it_q.win_10;
			4'd4: px = it_q.win_11;
			4'd5: px = it_q.win_12;
			4'd6: px = it_q.win_20;
			4'd7: px = it_q.win_21;
			default: px = it_q.win_22;
		endcase
		trial = {rem_q, num_q[35]} - {17'd0, den_q};
	end

	assign item_stall = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			step_q <= '0;
			bit_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						it_q <= item;
						step_q <= '0;
						sum_q <= '0;
						div_q <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					sum_q <= sum_q + 36'(k * $signed({1'b0, px}));
					div_q <= div_q + 20'(k);
					if (step_q == 4'd8) begin
						state_q <= ST_DIV;
						step_q <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
					if (step_q == 4'd8) begin
						// load divider next cycle via bit_q==37 marker
						bit_q <= 6'd37;
					end
				end
				ST_DIV: begin
					if (bit_q == 6'd37) begin
						num_q <= sum_q[35] ? 36'(-sum_q) : sum_q;
						den_q <= (div_q == 0) ? 20'd1 : (div_q[19] ? 20'(-div_q) : div_q);
						neg_q <= sum_q[35] ^ (div_q[19] && div_q != 0);
						rem_q <= '0;
						quo_q <= '0;
						bit_q <= 6'd36;
					end else if (bit_q != 0) begin
						if (!trial[36]) begin
							rem_q <= trial[35:0];
							quo_q <= {quo_q[34:0], 1'b1};
						end else begin
							rem_q <= {rem_q[34:0], num_q[35]};
							quo_q <= {quo_q[34:0], 1'b0};
						end
						num_q <= {num_q[34:0], 1'b0};
						bit_q <= bit_q - 6'd1;
					end else begin
						if (neg_q && quo_q != 0)
							out_pixel <= 8'd0;
						else if (quo_q > 36'(PIX_MAX))
							out_pixel <= PIX_MAX;
						else
							out_pixel <= quo_q[7:0];
						column_done <= it_q.column_done;
						tile_done <= it_q.tile_done;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "conv3x3_tile_filter_macros.svh"
	`C3_ASSERT(a_out_state, out_valid |-> (state_q == ST_OUT), "valid outside output state")
	`C3_ASSERT(a_hold_out, (out_valid && stall) |=> (out_valid && $stable(out_pixel)), "result lost")
	`C3_ASSERT_NEVER(a_step, (state_q == ST_MAC) && (step_q > 4'd8), "step overrun")
endmodule

@@ hw/rtl/conv3x3_tile_filter.sv @@
// Normalized 3x3 convolution over a column-major pixel stream. The front end
// keeps the two previous columns and builds one window per pixel, one pixel
// per cycle while the back end is free; the back end does nine multiply-adds
// and a 36-step restoring divide, one after the other, so an item that yields
// a result holds the back end through the MAC, the divide and any output
// stall, and stage 1 holds the next pixel until the back end is free. Pixels
// that make no result (first two columns and rows) do not enter the back end,
// but they too wait while it is busy.
module conv3x3_tile_filter import c3tf_pkg::*; #(
	parameter int TILE_ROWS = TILE_ROWS_DEF,
	parameter int MAX_TILE_COLUMNS = MAX_TILE_COLUMNS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_pixel,
	output logic                 column_done,
	output logic                 tile_done,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [47:0]          cfg_data
);
	logic [10:0] tile_columns_q;
	logic [47:0] coef_row0_q, coef_row1_q, coef_row2_q;
	logic item_valid, item_stall;
	win_item_t item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_columns_q <= 11'd64;
			coef_row0_q <= '0;
			coef_row1_q <= '0;
			coef_row2_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TILE_COLUMNS: tile_columns_q <= cfg_data[10:0];
				REG_COEF_ROW0:    coef_row0_q <= cfg_data;
				REG_COEF_ROW1:    coef_row1_q <= cfg_data;
				REG_COEF_ROW2:    coef_row2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	c3tf_front #(.TILE_ROWS(TILE_ROWS), .MAX_TILE_COLUMNS(MAX_TILE_COLUMNS)) u_front (
		.clk, .arst_n, .in_valid, .pixel, .in_stall,
		.tile_columns(tile_columns_q),
		.item_valid, .item, .item_stall
	);

	c3tf_back u_back (
		.clk, .arst_n, .item_valid, .item, .item_stall,
		.coef_row0(coef_row0_q), .coef_row1(coef_row1_q), .coef_row2(coef_row2_q),
		.out_valid, .stall(out_stall), .out_pixel, .column_done, .tile_done
	);
endmodule

@@ sim/conv3x3_tile_filter_tb.sv @@
module conv3x3_tile_filter_tb;
	import c3tf_pkg::*;

	localparam int COL_LEN = TILE_ROWS_DEF + 2;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_PIXELS = 240;

	typedef struct {
		logic [7:0] out_pixel;
		logic       column_done;
		logic       tile_done;
	} conv_result_t;

	typedef struct {
		logic [10:0] tile_cols;
		logic [47:0] c0, c1, c2;
		int          count;
		bit          random_pix;
		logic [7:0]  value;
		bit          known;
		logic [7:0]  known_out;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           pixel;
	logic                 out_valid;
	logic                 out_stall;
	logic [7:0]           out_pixel;
	logic                 column_done;
	logic                 tile_done;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [47:0]          cfg_data;

	conv3x3_tile_filter dut (.*);

	// predictor state
	logic [10:0] m_tile_cols;
	logic [47:0] m_coef [3];
	logic [7:0]  m_older [COL_LEN];
	logic [7:0]  m_middle [COL_LEN];
	logic [10:0] m_col;
	logic [10:0] m_row;
	logic [15:0] m_last_two;

	conv_result_t pending_results[$];
	int  errors;
	int  cycles;
	bit  row_known;
	logic [7:0] row_known_out;
	bit  no_idle;
	int  out_hold;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("conv3x3_tile_filter test failed");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("MISMATCH at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	function automatic void shift_entry(input int k, input logic [7:0] v);
		if (k < COL_LEN) begin
			m_older[k] = m_middle[k];
			m_middle[k] = v;
		end
	endfunction

	task automatic predict_pixel(input logic [7:0] p);
		int r, c, cols, divisor, acc, q, w;
		bit col_end, tile_end;
		logic [7:0] win [3][3];
		conv_result_t res;
		r = m_row;
		c = m_col;
		cols = (m_tile_cols > 1024) ? 1024 : m_tile_cols;
		col_end = (r >= COL_LEN - 1);
		tile_end = col_end && (c >= cols + 1);
		if (c >= 2 && r >= 2 && r < COL_LEN) begin
			for (int i = 0; i < 3; i++) begin
				win[i][0] = m_older[r - 2 + i];
				win[i][1] = m_middle[r - 2 + i];
			end
			win[0][2] = m_last_two[15:8];
			win[1][2] = m_last_two[7:0];
			win[2][2] = p;
			divisor = 0;
			acc = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					w = $signed(m_coef[i][16*j +: 16]);
					divisor += w;
					acc += w * int'(win[i][j]);
				end
			if (divisor == 0)
				divisor = 1;
			q = acc / divisor;
			if (q > 255)
				q = 255;
			if (q < 0)
				q = 0;
			res.out_pixel = q[7:0];
			res.column_done = col_end;
			res.tile_done = tile_end;
			if (row_known && res.out_pixel !== row_known_out)
				report($sformatf("predicted %0d, table says %0d", res.out_pixel, row_known_out));
			pending_results.push_back(res);
		end
		if (r >= 2)
			shift_entry(r - 2, m_last_two[15:8]);
		if (col_end) begin
			shift_entry(r - 1, m_last_two[7:0]);
			shift_entry(r, p);
		end
		m_last_two = {m_last_two[7:0], p};
		if (col_end) begin
			m_row = 0;
			m_col = tile_end ? 11'd0 : m_col + 11'd1;
		end else begin
			m_row = m_row + 11'd1;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TILE_COLUMNS: m_tile_cols = data[10:0];
			REG_COEF_ROW0: m_coef[0] = data;
			REG_COEF_ROW1: m_coef[1] = data;
			REG_COEF_ROW2: m_coef[2] = data;
			default: ;
		endcase
	endtask

	task automatic send_pixel(input logic [7:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= v;
		do @(posedge clk); while (in_stall);
		predict_pixel(v);
	endtask

	task automatic drain;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] rand_coefs(input bit narrow);
		logic [47:0] v;
		for (int j = 0; j < 3; j++)
			v[16*j +: 16] = narrow ? 16'($signed($urandom_range(0, 8)) - 4) : 16'($urandom);
		return v;
	endfunction

	task automatic run_plan(input plan_row_t pr);
		drain();
		write_reg(REG_TILE_COLUMNS, {37'd0, pr.tile_cols});
		write_reg(REG_COEF_ROW0, pr.c0);
		write_reg(REG_COEF_ROW1, pr.c1);
		write_reg(REG_COEF_ROW2, pr.c2);
		row_known = pr.known;
		row_known_out = pr.known_out;
		no_idle = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < pr.count; i++)
			send_pixel(pr.random_pix ? rand_pixel() : pr.value);
		in_valid <= 1'b0;
		row_known = 0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report("result with nothing expected");
				end else begin
					conv_result_t e;
					e = pending_results.pop_front();
					if (out_pixel !== e.out_pixel)
						report($sformatf("out_pixel %0d, expected %0d", out_pixel, e.out_pixel));
					if (column_done !== e.column_done)
						report($sformatf("column_done %b, expected %b", column_done, e.column_done));
					if (tile_done !== e.tile_done)
						report($sformatf("tile_done %b, expected %b", tile_done, e.tile_done));
				end
				out_hold = no_idle ? 0 : $urandom_range(0, 7);
			end
			if (out_hold > 0) begin
				out_stall <= 1'b1;
				out_hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	plan_row_t plan [$];
	plan_row_t pr;
	int sent;

	initial begin
		cycles = 0;
		errors = 0;
		out_hold = 0;
		row_known = 0;
		no_idle = 0;
		arst_n = 0;
		in_valid = 0;
		pixel = 0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_index = REG_TILE_COLUMNS;
		cfg_data = 0;
		m_tile_cols = 11'd64;
		for (int i = 0; i < 3; i++)
			m_coef[i] = 0;
		for (int i = 0; i < COL_LEN; i++) begin
			m_older[i] = 0;
			m_middle[i] = 0;
		end
		m_col = 0;
		m_row = 0;
		m_last_two = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tile_cols, coef rows, count, random, value, known, expected
		plan.push_back('{11'd1, 48'h000100010001, 48'h000100010001, 48'h000100010001,
			198, 0, 8'd200, 1, 8'd200});
		plan.push_back('{11'd1, 48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF,
			198, 0, 8'd255, 1, 8'd255});
		plan.push_back('{11'd1, 48'h800080008000, 48'h800080008000, 48'h800080008000,
			198, 0, 8'd255, 1, 8'd255});
		plan.push_back('{11'd1, 48'h0, 48'h0, 48'h0, 140, 0, 8'd77, 1, 8'd0});
		plan.push_back('{11'd2, 48'h0000FFFF0001, 48'h0, 48'h0, 200, 1, 8'd0, 0, 8'd0});
		plan.push_back('{11'd0, 48'h000100010001, 48'h0, 48'h0, 132, 1, 8'd0, 0, 8'd0});
		plan.push_back('{11'd2047, 48'h0001FFFE0003, 48'hFFFF00050002, 48'h000200000001,
			150, 1, 8'd0, 0, 8'd0});
		plan.push_back('{11'd3, 48'hFFFF00020001, 48'h000300040001, 48'hFFFE00010002,
			120, 1, 8'd0, 0, 8'd0});
		plan.push_back('{11'd1024, 48'h000100010001, 48'h000100080001, 48'h000100010001,
			80, 1, 8'd0, 0, 8'd0});
		foreach (plan[i])
			run_plan(plan[i]);

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			pr.tile_cols = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(1024, 2047))
				: 11'($urandom_range(0, 4));
			pr.c0 = rand_coefs($urandom_range(0, 1));
			pr.c1 = rand_coefs($urandom_range(0, 1));
			pr.c2 = rand_coefs($urandom_range(0, 1));
			pr.count = $urandom_range(40, 120);
			if (pr.count > RANDOM_PIXELS - sent)
				pr.count = RANDOM_PIXELS - sent;
			pr.random_pix = 1;
			pr.value = 0;
			pr.known = 0;
			pr.known_out = 0;
			run_plan(pr);
			sent += pr.count;
		end

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("conv3x3_tile_filter test passed");
		else
			$display("conv3x3_tile_filter test failed");
		$finish;
	end

endmodule
